// ----- rtl/assert_macros.svh -----
// Assertion macros used by the insertion sort datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising clk edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/isort_pkg.sv -----
// Package: shared types and constants of the insertion sort engine.
`timescale 1ns / 1ps
package isort_pkg;

    // Width of the key fields at the ports.
    localparam int FIELD_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_TAIL,
        S_EMIT,
        S_DRAIN
    } state_t;

    // Controller -> datapath commands.
    typedef struct packed {
        logic capture;    // latch key, mark, insert position; prefetch top entry
        logic set_ovf;    // key dropped, store full
        logic shift;      // move entry at pos-1 up to pos
        logic place;      // write key at pos, bump count
        logic emit_read;  // read next sorted entry for output
        logic finish;     // end of set: clear count, overflow and emit index
    } cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic full;       // store holds DEPTH keys
        logic pos_zero;   // insert position at bottom of store
        logic greater;    // prefetched entry is greater than the key
        logic last;       // captured key carried the end mark
        logic emit_end;   // emit index points at the final stored key
    } stat_t;

endpackage

// ----- rtl/isort_dp.sv -----
// Datapath: key store, insert position, count, overflow flag and output registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module isort_dp #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  isort_pkg::cmd_t                   cmd,
    output isort_pkg::stat_t                  st,
    input  logic [isort_pkg::FIELD_W-1:0]     key_value,
    input  logic                              last_key,
    output logic                              result_strobe,
    output logic [isort_pkg::FIELD_W-1:0]     sorted_value,
    output logic                              last_sorted,
    output logic                              overflowed
);
    import isort_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (KEY_WIDTH > FIELD_W) ? KEY_WIDTH : FIELD_W;

    logic [KEY_WIDTH-1:0] key_store [DEPTH];

    logic [CW-1:0]        count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [AW-1:0]        emit_idx_reg, emit_idx_next;
    logic                 pend_reg, pend_next;
    logic                 pend_last_reg, pend_last_next;

    logic [KEY_WIDTH-1:0] key_reg;
    logic                 last_reg;
    logic [AW-1:0]        pos_reg;
    logic [KEY_WIDTH-1:0] rd_data_reg;

    logic [XW-1:0]        key_ext;
    logic [XW-1:0]        out_ext;
    logic [CW-1:0]        cnt_m1;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;

    assign key_ext = XW'(key_value);
    assign out_ext = XW'(rd_data_reg);
    assign cnt_m1  = count_reg - CW'(1);

    // Read port: prefetch for insertion walk or sequential emission.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = emit_idx_reg;
        if (cmd.capture)
        begin
            rd_en   = (count_reg != '0);
            rd_addr = cnt_m1[AW-1:0];
        end
        else if (cmd.shift)
        begin
            rd_en   = (pos_reg > AW'(1));
            rd_addr = pos_reg - AW'(2);
        end
        else if (cmd.emit_read)
        begin
            rd_en   = 1'b1;
            rd_addr = emit_idx_reg;
        end
    end

    // Write port: shifted entry or the new key, always at the insert position.
    assign wr_en   = cmd.shift | cmd.place;
    assign wr_addr = pos_reg;
    assign wr_data = cmd.shift ? rd_data_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_store[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= key_store[rd_addr];
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg  <= key_ext[KEY_WIDTH-1:0];
            last_reg <= last_key;
            pos_reg  <= count_reg[AW-1:0];
        end
        else if (cmd.shift)
        begin
            pos_reg <= pos_reg - AW'(1);
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        emit_idx_next  = emit_idx_reg;
        pend_next      = cmd.emit_read;
        pend_last_next = pend_last_reg;
        if (cmd.place)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.emit_read)
        begin
            emit_idx_next  = emit_idx_reg + AW'(1);
            pend_last_next = st.emit_end;
        end
        if (cmd.finish)
        begin
            count_next    = '0;
            ovf_next      = 1'b0;
            emit_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            emit_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            emit_idx_reg  <= emit_idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    assign st.full     = (count_reg == CW'(DEPTH));
    assign st.pos_zero = (pos_reg == '0);
    assign st.greater  = (rd_data_reg > key_reg);
    assign st.last     = last_reg;
    assign st.emit_end = (CW'(emit_idx_reg) == cnt_m1);

    assign result_strobe = pend_reg;
    assign sorted_value  = out_ext[FIELD_W-1:0];
    assign last_sorted   = pend_last_reg;
    assign overflowed    = ovf_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "key count above capacity")
    `ASSERT_ALWAYS(a_one_write, $onehot0({cmd.shift, cmd.place}), "shift and place together")
    `ASSERT_IMPLY(a_shift_pos, cmd.shift, pos_reg != '0, "shift below bottom of store")
    `ASSERT_NEXT(a_last_ends, pend_reg && pend_last_reg, !pend_reg, "result after final one")

endmodule

// ----- rtl/isort_ctrl.sv -----
// Controller: sequences capture, insertion walk, emission and end of set.
`timescale 1ns / 1ps
module isort_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output isort_pkg::cmd_t   cmd,
    input  isort_pkg::stat_t  st
);
    import isort_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (st.full)
                    begin
                        cmd.set_ovf = 1'b1;
                        state_next  = S_TAIL;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                // stop at bottom or at first entry not greater than the key
                if (st.pos_zero || !st.greater)
                begin
                    cmd.place  = 1'b1;
                    state_next = st.last ? S_EMIT : S_IDLE;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            S_TAIL:
            begin
                state_next = st.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                cmd.emit_read = 1'b1;
                if (st.emit_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/insertion_sort_engine_unit.sv -----
// Top level: insertion sort engine, controller plus datapath with key store.
//
//  Channel   Direction  Handshake                     Payload
//  --------  ---------  ----------------------------  --------------------------------------
//  input     in         start & !busy                 key_value[31:0], last_key
//  result    out        result_strobe (one cycle)     sorted_value[31:0], last_sorted,
//                                                     overflowed
//
//  A key transaction takes a capture, then one shift for each stored key greater than
//  the new key (0 .. DEPTH-1), then a place: one shift per cycle through the write
//  port of the key store. A key dropped on a full store takes a capture and a tail state.
//  A marked key then starts emission: one result per cycle, then a closing state.
//  rst_n (async, active low) empties the set; the store itself needs no clearing.
//  The receiver cannot stall; results leave on result_strobe regardless.
`timescale 1ns / 1ps
module insertion_sort_engine_unit #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [isort_pkg::FIELD_W-1:0]  key_value,
    input  logic                           last_key,
    output logic                           result_strobe,
    output logic [isort_pkg::FIELD_W-1:0]  sorted_value,
    output logic                           last_sorted,
    output logic                           overflowed
);
    import isort_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // Sequencer: idle -> insertion walk or tail -> (emission -> close) -> idle.
    isort_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .st    (st)
    );

    // Key store (one write, one registered read), count, overflow and result regs.
    isort_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .key_value     (key_value),
        .last_key      (last_key),
        .result_strobe (result_strobe),
        .sorted_value  (sorted_value),
        .last_sorted   (last_sorted),
        .overflowed    (overflowed)
    );

endmodule
